// ===== rtl/plip_pkg.sv =====
// Package for the piecewise linear interpolator.
// Holds command codes, fixed constants and the controller/datapath structs.
// No dependencies.
`default_nettype none

package plip_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int          REG_POINTS_IN_USE = 0;
  localparam int          POINTS_W          = 11;
  localparam logic [10:0] POINTS_RESET      = 11'd1024;

  localparam logic [31:0] NOT_FOUND_VALUE = 32'hFFFF_0000;
  localparam logic [31:0] SAT_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN         = 32'h8000_0000;

  // multiplier: one bit of d per step; divider: one quotient bit per step
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 65;
  localparam int STEP_W    = 7;

  typedef struct packed {
    logic load;
    logic start_query;
    logic shift_x;
    logic rewind;
    logic shift_y;
    logic setup;
    logic mul_step;
    logic div_step;
    logic emit_hit;
    logic emit_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_small;
    logic hit;
    logic last;
    logic w_zero;
    logic mul_last;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator over a breakpoint table; top level.
// Load: no result, busy stays low.
// Query: scans one segment per cycle, then for the first matching segment runs a
// 32-step multiply and a 65-step divide; a zero-width segment skips both.
// No match: miss result once the scan reaches n = points in use capped at
// TABLE_DEPTH; miss without a scan when n < 2. Next word taken in the done cycle.
// Sync reset clears only the control state, done and points_in_use.
`default_nettype none

module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [9:0]  entry_index,
  input  wire logic [31:0] entry_x,
  input  wire logic [31:0] entry_y,
  input  wire logic [31:0] query_x,
  output logic             done,
  output logic             found,
  output logic [31:0]      result_y,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import plip_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [POINTS_W-1:0]   points_in_use;

  plip_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .points_in_use (points_in_use)
  );

  plip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  plip_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .points_in_use (points_in_use),
    .entry_index   (entry_index),
    .entry_x       (entry_x),
    .entry_y       (entry_y),
    .query_x       (query_x),
    .status        (status),
    .done          (done),
    .found         (found),
    .result_y      (result_y)
  );

endmodule

`default_nettype wire

// ===== rtl/plip_regs.sv =====
// APB-style configuration register of the interpolator.
// Holds points_in_use; depends on plip_pkg.
`default_nettype none

module plip_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [plip_pkg::POINTS_W-1:0] points_in_use
);
  import plip_pkg::*;

  logic wr_en;
  logic [1:0] reg_index;

  // single register, byte lanes within its word ignored
  assign reg_index = paddr >> 2;
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= POINTS_RESET;
    end else if (wr_en && (32'(reg_index) == REG_POINTS_IN_USE)) begin
      points_in_use <= pwdata[POINTS_W-1:0];
    end
  end

  assign prdata = {{(32-POINTS_W){1'b0}}, points_in_use};

endmodule

`default_nettype wire

// ===== rtl/plip_ctrl.sv =====
// Controller state machine of the interpolator.
// Sequences load, scan, y fetch, multiply and divide; depends on plip_pkg.
`default_nettype none

module plip_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   command,
  input  wire plip_pkg::dp_status_t   status,
  output logic                        busy,
  output plip_pkg::ctrl_cmd_t         cmd
);
  import plip_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH0 = 4'd1;
  localparam logic [3:0] S_FETCH1 = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_Y0     = 4'd4;
  localparam logic [3:0] S_Y1     = 4'd5;
  localparam logic [3:0] S_SETUP  = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (command == CMD_LOAD)) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          cmd.start_query = 1'b1;
          if (status.n_small) begin
            cmd.emit_miss = 1'b1;
          end else begin
            state_next = S_FETCH0;
          end
        end
      end
      S_FETCH0: begin
        cmd.shift_x = 1'b1;
        state_next  = S_FETCH1;
      end
      S_FETCH1: begin
        cmd.shift_x = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.rewind = 1'b1;
          state_next = S_Y0;
        end else if (status.last) begin
          cmd.emit_miss = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.shift_x = 1'b1;
        end
      end
      S_Y0: begin
        cmd.shift_y = 1'b1;
        state_next  = S_Y1;
      end
      S_Y1: begin
        cmd.shift_y = 1'b1;
        state_next  = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = status.w_zero ? S_FINISH : S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit_hit = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plip_dp.sv =====
// Datapath of the interpolator: breakpoint memories, scan compare,
// serial multiplier, serial divider and saturating output. Depends on plip_pkg.
`default_nettype none

module plip_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire plip_pkg::ctrl_cmd_t           cmd,
  input  wire logic [plip_pkg::POINTS_W-1:0] points_in_use,
  input  wire logic [9:0]                    entry_index,
  input  wire logic [31:0]                   entry_x,
  input  wire logic [31:0]                   entry_y,
  input  wire logic [31:0]                   query_x,
  output plip_pkg::dp_status_t               status,
  output logic                               done,
  output logic                               found,
  output logic [31:0]                        result_y
);
  import plip_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] x_mem [TABLE_DEPTH];
  logic [31:0] y_mem [TABLE_DEPTH];

  logic [CW-1:0]      n;
  logic [CW-1:0]      n_eff;
  logic [CW-1:0]      addr;
  logic signed [31:0] qx;
  logic signed [31:0] x_prev;
  logic signed [31:0] x_rd;
  logic signed [31:0] y_prev;
  logic signed [31:0] y_rd;
  logic signed [31:0] y0;
  logic               neg;
  logic [32:0]        mag;
  logic [31:0]        w;
  logic [65:0]        p;
  logic [31:0]        rem;
  logic [STEP_W-1:0]  cnt;

  logic [32:0] d_full;
  logic [32:0] w_full;
  logic [32:0] dy;
  logic [34:0] mul_sum;
  logic [32:0] div_try;
  logic        div_ge;
  logic [33:0] y0_ext;
  logic [33:0] q_ext;
  logic [33:0] r_sum;
  logic [31:0] r_sat;

  assign n_eff = (32'(points_in_use) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(points_in_use);

  // load
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(entry_index) < TABLE_DEPTH)) begin
      x_mem[AW'(entry_index)] <= entry_x;
      y_mem[AW'(entry_index)] <= entry_y;
    end
  end

  // registered reads, x and y shift pairs
  always_ff @(posedge clk) begin
    if (cmd.shift_x) begin
      x_rd   <= x_mem[addr[AW-1:0]];
      x_prev <= x_rd;
    end
    if (cmd.shift_y) begin
      y_rd   <= y_mem[addr[AW-1:0]];
      y_prev <= y_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      addr <= '0;
      n    <= n_eff;
      qx   <= query_x;
    end else if (cmd.rewind) begin
      addr <= addr - CW'(2);
    end else if (cmd.shift_x || cmd.shift_y) begin
      addr <= addr + CW'(1);
    end
  end

  assign d_full = {qx[31], qx} - {x_prev[31], x_prev};
  assign w_full = {x_rd[31], x_rd} - {x_prev[31], x_prev};
  assign dy     = {y_rd[31], y_rd} - {y_prev[31], y_prev};

  assign mul_sum = {1'b0, p[65:32]} + (p[0] ? {2'b00, mag} : 35'd0);
  assign div_try = {rem, p[64]};
  assign div_ge  = (div_try >= {1'b0, w});

  // setup, shift-add multiply of mag by d, restoring divide by w
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      y0  <= y_prev;
      neg <= dy[32];
      mag <= dy[32] ? (33'd0 - dy) : dy;
      w   <= w_full[31:0];
      p   <= (w_full[31:0] == 32'd0) ? 66'd0 : {34'd0, d_full[31:0]};
      rem <= '0;
      cnt <= '0;
    end else if (cmd.mul_step) begin
      p   <= {mul_sum[33:0], p[31:0]} >> 1;
      cnt <= status.mul_last ? '0 : cnt + STEP_W'(1);
    end else if (cmd.div_step) begin
      rem <= div_ge ? 32'(div_try - {1'b0, w}) : div_try[31:0];
      p   <= {p[64:0], div_ge};
      cnt <= cnt + STEP_W'(1);
    end
  end

  assign status.n_small  = (n_eff < CW'(2));
  assign status.hit      = (qx >= x_prev) && (qx <= x_rd);
  assign status.last     = (addr == n);
  assign status.w_zero   = (w_full[31:0] == 32'd0);
  assign status.mul_last = (cnt == STEP_W'(MUL_STEPS - 1));
  assign status.div_last = (cnt == STEP_W'(DIV_STEPS - 1));

  assign y0_ext = {{2{y0[31]}}, y0};
  assign q_ext  = {1'b0, p[32:0]};
  assign r_sum  = neg ? (y0_ext - q_ext) : (y0_ext + q_ext);

  always_comb begin
    if (!r_sum[33] && (r_sum[32:31] != 2'b00)) begin
      r_sat = SAT_MAX;
    end else if (r_sum[33] && (r_sum[32:31] != 2'b11)) begin
      r_sat = SAT_MIN;
    end else begin
      r_sat = r_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_hit || cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      found    <= 1'b1;
      result_y <= r_sat;
    end else if (cmd.emit_miss) begin
      found    <= 1'b0;
      result_y <= NOT_FOUND_VALUE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plip_checker.sv =====
// Port-level checker for the interpolator, with its bind to the top level.
// Depends on plip_pkg and piecewise_linear_interpolator.
`default_nettype none

module plip_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        command,
  input wire logic        done,
  input wire logic        found,
  input wire logic [31:0] result_y
);
  import plip_pkg::*;

  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_LOAD)) |=> !busy)
    else $error("load word made the block busy");

  a_busy_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (command == CMD_QUERY)))
    else $error("busy rose without a query word");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (result_y == NOT_FOUND_VALUE))
    else $error("not-found result word has wrong value");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a query is running");

  a_hit_after_busy: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> $past(busy))
    else $error("found result word without a running query");

endmodule

bind piecewise_linear_interpolator plip_checker u_plip_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .command  (command),
  .done     (done),
  .found    (found),
  .result_y (result_y)
);

`default_nettype wire

// ===== tb/piecewise_linear_interpolator_tb.sv =====
`timescale 1ns / 100ps
// Testbench for piecewise_linear_interpolator: loads breakpoint tables over the word port,
// queries them and checks each result against an interpolation predictor of its own.
// Depends on plip_pkg and the piecewise_linear_interpolator top level.

module piecewise_linear_interpolator_tb;
  import plip_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct {
    logic        cmd;
    logic [9:0]  idx;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] qx;
    bit          drain;
  } word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] y;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        command = CMD_LOAD;
  logic [9:0]  entry_index = '0;
  logic [31:0] entry_x = '0;
  logic [31:0] entry_y = '0;
  logic [31:0] query_x = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         busy;
  wire         done;
  wire         found;
  wire  [31:0] result_y;
  wire  [31:0] prdata;
  wire         pready;

  word_t              pending[$];
  outcome_t           results_due[$];
  logic signed [31:0] bp_x [DEPTH];
  logic signed [31:0] bp_y [DEPTH];
  logic [10:0]        shadow_points = POINTS_RESET;
  logic signed [31:0] plan_x [DEPTH];
  logic signed [31:0] plan_y [DEPTH];
  int                 mismatches = 0;
  int                 words_queued = 0;
  int                 max_idle = 7;
  int                 idle_left = 0;
  bit                 word_held = 1'b0;
  bit                 took_word = 1'b0;
  bit                 drv_idle = 1'b1;

  piecewise_linear_interpolator #(.TABLE_DEPTH(DEPTH)) dut (.*);

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // first enclosing segment wins; product exact, quotient truncated toward zero
  function automatic outcome_t interpolate(input logic [31:0] qx);
    outcome_t           res;
    int                 segs;
    logic signed [69:0] q, x0, x1, y0, acc;
    res.found = 1'b0;
    res.y = NOT_FOUND_VALUE;
    segs = (shadow_points > DEPTH) ? DEPTH : int'(shadow_points);
    q = $signed(qx);
    for (int i = 0; i + 1 < segs && !res.found; i++) begin
      x0 = bp_x[i];
      x1 = bp_x[i + 1];
      if (q >= x0 && q <= x1) begin
        y0 = bp_y[i];
        acc = y0;
        if (x1 != x0) acc = y0 + (q - x0) * (bp_y[i + 1] - y0) / (x1 - x0);
        if (acc > $signed(SAT_MAX)) res.y = SAT_MAX;
        else if (acc < $signed(SAT_MIN)) res.y = SAT_MIN;
        else res.y = acc[31:0];
        res.found = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : result_monitor
    outcome_t want;
    took_word = 1'b0;
    if (!rst) begin
      if (done) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result %h with no query outstanding", result_y));
        end else begin
          want = results_due.pop_front();
          if (found !== want.found)
            flag_mismatch($sformatf("found %b, expected %b", found, want.found));
          if (result_y !== want.y)
            flag_mismatch($sformatf("result_y %h, expected %h", result_y, want.y));
        end
      end
      if (start && !busy) begin
        took_word = 1'b1;
        if (command == CMD_LOAD) begin
          bp_x[entry_index] = entry_x;
          bp_y[entry_index] = entry_y;
        end else begin
          results_due.push_back(interpolate(query_x));
        end
      end
    end
  end

  always @(negedge clk) begin : word_driver
    word_t nxt;
    if (!rst) begin
      if (took_word) word_held = 1'b0;
      if (!word_held) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending.size() != 0 &&
                     (!pending[0].drain || (results_due.size() == 0 && !busy))) begin
          nxt = pending.pop_front();
          command <= nxt.cmd;
          entry_index <= nxt.idx;
          entry_x <= nxt.ex;
          entry_y <= nxt.ey;
          query_x <= nxt.qx;
          word_held = 1'b1;
          idle_left = $urandom_range(0, max_idle);
        end
      end
      start <= word_held;
    end
    drv_idle = !word_held && pending.size() == 0;
  end

  task automatic queue_load(input int idx, input logic [31:0] x, input logic [31:0] y);
    word_t w;
    w.cmd = CMD_LOAD;
    w.idx = 10'(idx);
    w.ex = x;
    w.ey = y;
    w.qx = $urandom;
    w.drain = 1'b0;
    plan_x[idx] = x;
    pending.push_back(w);
    words_queued++;
  endtask

  task automatic queue_query(input logic [31:0] qx, input bit drain);
    word_t w;
    w.cmd = CMD_QUERY;
    w.idx = 10'($urandom);
    w.ex = $urandom;
    w.ey = $urandom;
    w.qx = qx;
    w.drain = drain;
    pending.push_back(w);
    words_queued++;
  endtask

  // sorted tables (fine, wide, stepped with repeats) or unsorted, loaded in shuffled order
  task automatic build_table(input int n);
    int     order [DEPTH];
    int     kind, j, tmp;
    longint pos, step;
    kind = $urandom_range(0, 3);
    if (kind == 1) pos = longint'($signed(SAT_MIN)) + longint'($urandom_range(0, 1000));
    else pos = $signed($urandom) >>> 4;
    for (int i = 0; i < n; i++) begin
      if (kind == 2) plan_x[i] = $urandom;
      else plan_x[i] = 32'(pos);
      if ($urandom_range(0, 1) == 1) plan_y[i] = $urandom;
      else plan_y[i] = $signed($urandom) >>> 12;
      order[i] = i;
      case (kind)
        0: step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 20);
        1: step = $urandom_range(0, 32'd4294965000 / n);
        default: step = $urandom_range(0, 1) << 16;
      endcase
      pos += step;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) queue_load(order[i], plan_x[order[i]], plan_y[order[i]]);
  endtask

  function automatic logic [31:0] pick_query(input int n);
    int     k;
    longint lo, hi, r;
    k = $urandom_range(0, n - 2);
    case ($urandom_range(0, 5))
      0, 1: return plan_x[$urandom_range(0, n - 1)];
      2, 3: begin
        lo = plan_x[k];
        hi = plan_x[k + 1];
        r = $urandom;
        if (hi > lo) return 32'(lo + r % (hi - lo + 1));
        return plan_x[k];
      end
      4: return $urandom;
      default: return ($urandom_range(0, 1) == 1) ? plan_x[0] - 1 : plan_x[n - 1] + 1;
    endcase
  endfunction

  task automatic settle();
    do begin
      @(negedge clk);
      @(posedge clk);
    end while (!(drv_idle && results_due.size() == 0 && !busy));
    repeat (4) @(posedge clk);
  endtask

  task automatic write_points(input logic [10:0] n);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * REG_POINTS_IN_USE);
    pwdata <= {21'($urandom), n};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_points = n;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[10:0] !== n)
      flag_mismatch($sformatf("points_in_use reads %h, expected %h", prdata[10:0], n));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int n, nq;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // two points spanning the full range
    settle();
    write_points(11'd2);
    queue_load(0, SAT_MIN, SAT_MAX);
    queue_load(1, SAT_MAX, SAT_MIN);
    queue_query(SAT_MIN, 1'b0);
    queue_query(SAT_MAX, 1'b0);
    queue_query(32'h0000_0000, 1'b1);
    queue_query(32'hFFFF_FFFF, 1'b0);
    queue_query(32'h0001_0000, 1'b0);
    // fewer than two points: nothing to scan
    settle();
    write_points(11'd0);
    queue_query(32'h0000_0000, 1'b0);
    settle();
    write_points(11'd1);
    queue_query(SAT_MIN, 1'b0);
    // zero-width first segment, exact end point, misses on both sides
    settle();
    write_points(11'd3);
    queue_load(0, 32'h0005_0000, 32'h0001_0000);
    queue_load(1, 32'h0005_0000, 32'h0007_0000);
    queue_load(2, 32'h000A_0000, 32'hFFFD_0000);
    queue_load(DEPTH - 1, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_query(32'h0005_0000, 1'b0);
    queue_query(32'h0007_0000, 1'b0);
    queue_query(32'h000A_0000, 1'b0);
    queue_query(32'h000B_0000, 1'b1);
    queue_query(32'h0004_0000, 1'b0);

    while (words_queued < 540) begin
      settle();
      case ($urandom_range(0, 9))
        0: n = 2;
        1: n = $urandom_range(17, 64);
        default: n = $urandom_range(3, 16);
      endcase
      max_idle = ($urandom_range(0, 3) == 0) ? 0 : 7;
      write_points(11'(n));
      build_table(n);
      nq = $urandom_range(8, 24);
      repeat (nq) begin
        case ($urandom_range(0, 9))
          0: queue_load($urandom_range(n, DEPTH - 1), $urandom, $urandom);
          1: queue_load($urandom_range(0, n - 1), $urandom, $urandom);
          default: queue_query(pick_query(n), $urandom_range(0, 15) == 0);
        endcase
      end
    end

    // whole table, then a point count beyond the table depth
    settle();
    max_idle = 7;
    write_points(11'(DEPTH));
    build_table(DEPTH);
    repeat (5) queue_query(pick_query(DEPTH), 1'b0);
    queue_query(SAT_MAX, 1'b0);
    settle();
    write_points(11'h7FF);
    repeat (3) queue_query(pick_query(DEPTH), 1'b0);

    settle();
    repeat (1200) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/plip_pkg.sv
rtl/plip_regs.sv
rtl/plip_ctrl.sv
rtl/plip_dp.sv
rtl/piecewise_linear_interpolator.sv
rtl/plip_checker.sv
tb/piecewise_linear_interpolator_tb.sv
